>>> rtl/spq_pkg.sv
// shared constants and types for the sorted priority queue
package spq_pkg;

	localparam int DEPTH_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;
	localparam int PRIO_WIDTH_DEF = 8;

	localparam logic CMD_INSERT = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	localparam int STATUS_W = 2;
	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// per-cell control for one update of the row
	typedef struct packed {
		logic ins;   // insert enabled this cycle
		logic rem;   // remove enabled this cycle
		logic occ;   // this cell holds an entry
	} cell_ctrl_t;

endpackage

>>> rtl/sorted_priority_queue.sv
// sorted priority queue top: row of cells, fill count and registered result
// a result is registered and is valid in the cycle after its input transfer
// throughput: one insert or remove per cycle while m_tready stays high
// the whole cell row updates in the same cycle, each cell looking only at its neighbors
// reset clears the fill count and the result valid; cell contents are not cleared
module sorted_priority_queue
	import spq_pkg::*;
#(
	parameter int DEPTH      = DEPTH_DEF,
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int PRIO_WIDTH = PRIO_WIDTH_DEF,
	localparam int CNT_W     = $clog2(DEPTH + 1),
	localparam int S_TDATA_W = ((DATA_WIDTH + PRIO_WIDTH + 7) / 8) * 8,
	localparam int M_TDATA_W = ((DATA_WIDTH + PRIO_WIDTH + CNT_W + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // data, priority_req
	input  logic                 s_tuser,   // cmd
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // out_data, out_priority, occupancy
	output logic [STATUS_W-1:0]  m_tuser    // status
);

	logic        [CNT_W-1:0]      count_q;
	logic                         m_valid_q;
	logic        [STATUS_W-1:0]   status_q;
	logic signed [DATA_WIDTH-1:0] out_data_q;
	logic        [PRIO_WIDTH-1:0] out_prio_q;

	logic signed [DATA_WIDTH-1:0] cell_data [DEPTH];
	logic        [PRIO_WIDTH-1:0] cell_prio [DEPTH];
	logic        [DEPTH-1:0]      cell_occ;

	logic                         accept;
	logic                         is_full;
	logic                         none_held;
	logic                         do_ins;
	logic                         do_rem;
	logic signed [DATA_WIDTH-1:0] in_data;
	logic        [PRIO_WIDTH-1:0] in_prio;

	assign in_data   = s_tdata[DATA_WIDTH-1:0];
	assign in_prio   = s_tdata[DATA_WIDTH+PRIO_WIDTH-1:DATA_WIDTH];
	assign s_tready  = !m_valid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign is_full   = (count_q == CNT_W'(DEPTH));
	assign none_held = (count_q == '0);
	assign do_ins    = accept && (s_tuser == CMD_INSERT) && !is_full;
	assign do_rem    = accept && (s_tuser == CMD_REMOVE) && !none_held;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctrl_t                   ctrl;
		logic                         p_occ;
		logic        [PRIO_WIDTH-1:0] p_prio;
		logic signed [DATA_WIDTH-1:0] p_data;
		logic        [PRIO_WIDTH-1:0] n_prio;
		logic signed [DATA_WIDTH-1:0] n_data;

		assign cell_occ[i] = (count_q > CNT_W'(i));
		assign ctrl.ins    = do_ins;
		assign ctrl.rem    = do_rem;
		assign ctrl.occ    = cell_occ[i];

		if (i == 0) begin : g_front
			// front cell sees a virtual neighbor of top priority
			assign p_occ  = 1'b1;
			assign p_prio = '1;
			assign p_data = '0;
		end else begin : g_mid
			assign p_occ  = cell_occ[i-1];
			assign p_prio = cell_prio[i-1];
			assign p_data = cell_data[i-1];
		end

		if (i == DEPTH - 1) begin : g_back
			assign n_prio = cell_prio[i];
			assign n_data = cell_data[i];
		end else begin : g_inner
			assign n_prio = cell_prio[i+1];
			assign n_data = cell_data[i+1];
		end

		spq_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.PRIO_WIDTH(PRIO_WIDTH)
		) u_cell (
			.clk      (clk),
			.ctrl     (ctrl),
			.prev_occ (p_occ),
			.prev_prio(p_prio),
			.prev_data(p_data),
			.next_prio(n_prio),
			.next_data(n_data),
			.new_prio (in_prio),
			.new_data (in_data),
			.prio_q   (cell_prio[i]),
			.data_q   (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (do_ins) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rem) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (accept) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	// result payload, loaded on each input transfer
	always_ff @(posedge clk) begin
		if (accept) begin
			priority if (s_tuser == CMD_INSERT && is_full) begin
				status_q <= ST_FULL;
			end else if (s_tuser == CMD_REMOVE && none_held) begin
				status_q <= ST_EMPTY;
			end else begin
				status_q <= ST_DONE;
			end
			if (do_rem) begin
				out_data_q <= cell_data[0];
				out_prio_q <= cell_prio[0];
			end else begin
				out_data_q <= '0;
				out_prio_q <= '0;
			end
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = status_q;
	assign m_tdata  = M_TDATA_W'({count_q, out_prio_q, out_data_q});

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count above depth");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == CMD_INSERT && is_full) |=> (m_tvalid && m_tuser == ST_FULL))
		else $error("insert into full queue not flagged");

	a_count_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && s_tuser == CMD_INSERT && is_full) |=> $stable(count_q))
		else $error("refused insert changed the fill count");

	a_front_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CNT_W'(2)) |-> (cell_prio[0] >= cell_prio[1]))
		else $error("front cells out of priority order");
`endif

endmodule

>>> rtl/spq_cell.sv
// one slot of the sorted row: keeps, takes the new entry, or takes a neighbor's entry
module spq_cell
	import spq_pkg::*;
#(
	parameter int DATA_WIDTH = DATA_WIDTH_DEF,
	parameter int PRIO_WIDTH = PRIO_WIDTH_DEF
) (
	input  logic                         clk,
	input  cell_ctrl_t                   ctrl,
	input  logic                         prev_occ,
	input  logic        [PRIO_WIDTH-1:0] prev_prio,
	input  logic signed [DATA_WIDTH-1:0] prev_data,
	input  logic        [PRIO_WIDTH-1:0] next_prio,
	input  logic signed [DATA_WIDTH-1:0] next_data,
	input  logic        [PRIO_WIDTH-1:0] new_prio,
	input  logic signed [DATA_WIDTH-1:0] new_data,
	output logic        [PRIO_WIDTH-1:0] prio_q,
	output logic signed [DATA_WIDTH-1:0] data_q
);

	logic prev_ge;
	logic own_lt;

	// new entry sits behind every entry of equal or higher priority
	assign prev_ge = prev_occ && (prev_prio >= new_prio);
	assign own_lt  = !ctrl.occ || (prio_q < new_prio);

	always_ff @(posedge clk) begin
		priority if (ctrl.rem) begin
			prio_q <= next_prio;
			data_q <= next_data;
		end else if (ctrl.ins && !prev_ge) begin
			prio_q <= prev_prio;
			data_q <= prev_data;
		end else if (ctrl.ins && own_lt) begin
			prio_q <= new_prio;
			data_q <= new_data;
		end
	end

endmodule
